>>> design/btmx_pkg.sv
// Package for the binary trie max-XOR block.
// Holds opcodes, status codes, the controller state type and the free pool command.
// Depends on nothing.
package btmx_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_STEP   = 7'b0000010,
        S_RDWAIT = 7'b0000100,
        S_CHECK  = 7'b0001000,
        S_ALLOC  = 7'b0010000,
        S_FLUSH  = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic pop;
        logic push;
    } pool_cmd_t;

endpackage

>>> design/btmx_node_mem.sv
// Node memory of the trie: one write port and one read port, registered read data.
// Each entry holds a use count and two child links. Depends on nothing.
module btmx_node_mem #(
    parameter int DEPTH  = 4096,
    parameter int DATA_W = 42,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/btmx_free_pool.sv
// Free node pool: a stack memory of released nodes plus a counter of nodes never used.
// Uses btmx_pkg for the pool command.
module btmx_free_pool
    import btmx_pkg::*;
#(
    parameter int NODE_COUNT = 4096,
    localparam int IDX_W = $clog2(NODE_COUNT),
    localparam int CNT_W = IDX_W + 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  pool_cmd_t        cmd,
    input  logic [IDX_W-1:0] push_idx,
    output logic [IDX_W-1:0] pop_idx,
    output logic [CNT_W-1:0] free_cnt
);

    logic [IDX_W-1:0] stack_mem [NODE_COUNT];
    logic [IDX_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] fresh_idx_reg;
    logic             from_stack_reg;
    logic [CNT_W-1:0] stack_cnt_reg;
    logic [CNT_W-1:0] fresh_reg;
    logic [CNT_W-1:0] free_reg;
    logic [CNT_W-1:0] top_m1;
    logic             push_ok;

    assign top_m1  = stack_cnt_reg - CNT_W'(1);
    assign push_ok = cmd.push && (free_reg < CNT_W'(NODE_COUNT));

    // Released nodes are reused first; untouched nodes come from the fresh counter.
    always_ff @(posedge aclk) begin
        if (push_ok) begin
            stack_mem[stack_cnt_reg[IDX_W-1:0]] <= push_idx;
        end
        if (cmd.pop) begin
            rd_data_reg   <= stack_mem[top_m1[IDX_W-1:0]];
            fresh_idx_reg <= fresh_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stack_cnt_reg  <= '0;
            fresh_reg      <= '0;
            free_reg       <= CNT_W'(NODE_COUNT);
            from_stack_reg <= 1'b0;
        end else if (cmd.pop) begin
            free_reg <= free_reg - CNT_W'(1);
            if (stack_cnt_reg != '0) begin
                stack_cnt_reg  <= top_m1;
                from_stack_reg <= 1'b1;
            end else begin
                fresh_reg      <= fresh_reg + CNT_W'(1);
                from_stack_reg <= 1'b0;
            end
        end else if (push_ok) begin
            free_reg      <= free_reg + CNT_W'(1);
            stack_cnt_reg <= stack_cnt_reg + CNT_W'(1);
        end
    end

    assign pop_idx  = from_stack_reg ? rd_data_reg : fresh_idx_reg;
    assign free_cnt = free_reg;

endmodule

>>> design/binary_trie_max_xor.sv
// Binary trie max-XOR: a query walks the trie once from the root, while insert and
// remove walk it twice, first a check pass and then an update pass.
// One request is worked at a time; one node memory read per level sets the pace, and
// a result that has not been taken holds the walker before it reports the next one.
// Reset (synchronous, active low) empties the set at once: no clearing pass is needed.
// Uses btmx_pkg, btmx_node_mem and btmx_free_pool.
module binary_trie_max_xor
    import btmx_pkg::*;
#(
    parameter int KEY_BITS   = 31,
    parameter int NODE_COUNT = 4096,
    parameter int COUNT_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_opcode,
    input  logic [KEY_BITS-1:0] s_key_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [KEY_BITS-1:0] m_max_xor,
    output logic [1:0]          m_status
);

    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int LINK_W = IDX_W + 1;
    localparam int ENT_W  = COUNT_BITS + 2 * LINK_W;
    localparam int CNT_W  = IDX_W + 1;
    localparam int LVL_W  = $clog2(KEY_BITS);
    localparam int DEP_W  = $clog2(KEY_BITS + 1);

    // A node entry is {count, link for bit one, link for bit zero}. A link of zero
    // is null and a link of n names node n-1. The root's links live in a register.

    state_t              state_reg, state_next;
    logic [1:0]          op_reg, op_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [KEY_BITS-1:0] res_reg, res_next;
    logic [1:0]          status_reg, status_next;
    logic [LVL_W-1:0]    lvl_reg, lvl_next;
    logic [DEP_W-1:0]    depth_reg, depth_next;
    logic                sat_reg, sat_next;
    logic                phase2_reg, phase2_next;
    logic                chain_reg, chain_next;
    logic                cur_root_reg, cur_root_next;
    logic [IDX_W-1:0]    cur_idx_reg, cur_idx_next;
    logic [ENT_W-1:0]    cur_ent_reg, cur_ent_next;
    logic [IDX_W-1:0]    nx_reg, nx_next;
    logic [2*LINK_W-1:0] root_reg, root_next;
    logic                m_valid_reg, m_valid_next;
    logic [KEY_BITS-1:0] m_max_xor_reg, m_max_xor_next;
    logic [1:0]          m_status_reg, m_status_next;

    logic                mem_we, mem_re;
    logic [IDX_W-1:0]    mem_waddr, mem_raddr;
    logic [ENT_W-1:0]    mem_wdata, mem_rdata;
    pool_cmd_t           pool_cmd;
    logic [IDX_W-1:0]    push_idx, pop_idx;
    logic [CNT_W-1:0]    free_cnt;

    logic                bit_b, last;
    logic [LINK_W-1:0]   link_b, link_nb, sel_link, sel_m1, new_link;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [ENT_W-1:0]    ent_inc, ent_dec;
    logic [ENT_W-1:0]    root_clr_ent, root_new_ent;
    logic [DEP_W-1:0]    need;
    logic                short_pool;

    function automatic logic [ENT_W-1:0] set_link(input logic [ENT_W-1:0] e,
                                                  input logic b,
                                                  input logic [LINK_W-1:0] v);
        logic [ENT_W-1:0] r;
        r = e;
        if (b) begin
            r[2*LINK_W-1:LINK_W] = v;
        end else begin
            r[LINK_W-1:0] = v;
        end
        return r;
    endfunction

    btmx_node_mem #(
        .DEPTH (NODE_COUNT),
        .DATA_W(ENT_W)
    ) u_node_mem (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    btmx_free_pool #(
        .NODE_COUNT(NODE_COUNT)
    ) u_free_pool (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (pool_cmd),
        .push_idx(push_idx),
        .pop_idx (pop_idx),
        .free_cnt(free_cnt)
    );

    // Link selection at the current level.
    assign bit_b   = key_reg[lvl_reg];
    assign last    = (lvl_reg == '0);
    assign link_b  = bit_b ? cur_ent_reg[2*LINK_W-1:LINK_W] : cur_ent_reg[LINK_W-1:0];
    assign link_nb = bit_b ? cur_ent_reg[LINK_W-1:0] : cur_ent_reg[2*LINK_W-1:LINK_W];
    assign sel_link = ((op_reg == OP_QUERY) && !chain_reg && (link_nb != '0)) ?
                      link_nb : link_b;
    assign sel_m1   = sel_link - LINK_W'(1);
    assign new_link = {1'b0, pop_idx} + LINK_W'(1);

    assign rd_cnt  = mem_rdata[ENT_W-1 -: COUNT_BITS];
    assign ent_inc = {rd_cnt + COUNT_BITS'(1), mem_rdata[2*LINK_W-1:0]};
    assign ent_dec = {rd_cnt - COUNT_BITS'(1), mem_rdata[2*LINK_W-1:0]};

    // Root links with the current branch cleared or pointed at the new node.
    assign root_clr_ent = set_link({{COUNT_BITS{1'b0}}, root_reg}, bit_b, '0);
    assign root_new_ent = set_link({{COUNT_BITS{1'b0}}, root_reg}, bit_b, new_link);

    // An insert needs one fresh node for every level below the deepest existing one.
    assign need       = DEP_W'(KEY_BITS) - depth_reg;
    assign short_pool = {{CNT_W{1'b0}}, need} > {{DEP_W{1'b0}}, free_cnt};

    // The controller reads one node per level. Every write goes to a node other than
    // the one read in the same or the next cycle, which acts as the interlock on the
    // memory: a read never meets a pending write to its own entry.
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        res_next       = res_reg;
        status_next    = status_reg;
        lvl_next       = lvl_reg;
        depth_next     = depth_reg;
        sat_next       = sat_reg;
        phase2_next    = phase2_reg;
        chain_next     = chain_reg;
        cur_root_next  = cur_root_reg;
        cur_idx_next   = cur_idx_reg;
        cur_ent_next   = cur_ent_reg;
        nx_next        = nx_reg;
        root_next      = root_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_max_xor_next = m_max_xor_reg;
        m_status_next  = m_status_reg;
        mem_we         = 1'b0;
        mem_waddr      = cur_idx_reg;
        mem_wdata      = cur_ent_reg;
        mem_re         = 1'b0;
        mem_raddr      = sel_m1[IDX_W-1:0];
        pool_cmd       = '0;
        push_idx       = nx_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next       = s_opcode;
                    key_next      = s_key_value;
                    res_next      = '0;
                    status_next   = ST_OK;
                    lvl_next      = LVL_W'(KEY_BITS - 1);
                    depth_next    = '0;
                    sat_next      = 1'b0;
                    phase2_next   = 1'b0;
                    chain_next    = 1'b0;
                    cur_root_next = 1'b1;
                    cur_ent_next  = {{COUNT_BITS{1'b0}}, root_reg};
                    case (s_opcode)
                        OP_INSERT, OP_REMOVE: begin
                            state_next = S_STEP;
                        end
                        OP_QUERY: begin
                            if (root_reg == '0) begin
                                status_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_STEP;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_STEP: begin
                nx_next = sel_m1[IDX_W-1:0];
                if (chain_reg) begin
                    // Releasing the rest of a chain whose head just reached zero.
                    if (link_b == '0) begin
                        state_next = S_DONE;
                    end else begin
                        pool_cmd.push = 1'b1;
                        push_idx      = sel_m1[IDX_W-1:0];
                        mem_re        = 1'b1;
                        state_next    = S_RDWAIT;
                    end
                end else begin
                    case (op_reg)
                        OP_QUERY: begin
                            if (link_nb != '0) begin
                                res_next[lvl_reg] = 1'b1;
                                mem_re            = 1'b1;
                                state_next        = S_RDWAIT;
                            end else if (link_b != '0) begin
                                mem_re     = 1'b1;
                                state_next = S_RDWAIT;
                            end else begin
                                state_next = S_DONE;
                            end
                        end
                        OP_INSERT: begin
                            if (link_b != '0) begin
                                mem_re     = 1'b1;
                                state_next = S_RDWAIT;
                            end else if (phase2_reg) begin
                                pool_cmd.pop = 1'b1;
                                state_next   = S_ALLOC;
                            end else begin
                                state_next = S_CHECK;
                            end
                        end
                        default: begin
                            if (link_b != '0) begin
                                mem_re     = 1'b1;
                                state_next = S_RDWAIT;
                            end else begin
                                status_next = ST_ABSENT;
                                state_next  = S_DONE;
                            end
                        end
                    endcase
                end
            end

            S_RDWAIT: begin
                lvl_next     = lvl_reg - LVL_W'(1);
                state_next   = S_STEP;
                cur_ent_next = mem_rdata;
                if (chain_reg || (op_reg == OP_QUERY)) begin
                    if (last) begin
                        state_next = S_DONE;
                    end
                end else if (op_reg == OP_INSERT) begin
                    if (!phase2_reg) begin
                        if (rd_cnt == {COUNT_BITS{1'b1}}) begin
                            sat_next = 1'b1;
                        end
                        depth_next = depth_reg + DEP_W'(1);
                        if (last) begin
                            state_next = S_CHECK;
                        end
                    end else begin
                        mem_we        = 1'b1;
                        mem_waddr     = nx_reg;
                        mem_wdata     = ent_inc;
                        cur_ent_next  = ent_inc;
                        cur_idx_next  = nx_reg;
                        cur_root_next = 1'b0;
                        if (last) begin
                            state_next = S_FLUSH;
                        end
                    end
                end else begin
                    if (!phase2_reg) begin
                        if (rd_cnt == '0) begin
                            status_next = ST_ABSENT;
                            state_next  = S_DONE;
                        end else if (last) begin
                            state_next = S_CHECK;
                        end
                    end else if (rd_cnt != COUNT_BITS'(1)) begin
                        mem_we        = 1'b1;
                        mem_waddr     = nx_reg;
                        mem_wdata     = ent_dec;
                        cur_ent_next  = ent_dec;
                        cur_idx_next  = nx_reg;
                        cur_root_next = 1'b0;
                        if (last) begin
                            state_next = S_DONE;
                        end
                    end else begin
                        // The count drops to zero: unhook the node and free its chain.
                        if (cur_root_reg) begin
                            root_next = root_clr_ent[2*LINK_W-1:0];
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = cur_idx_reg;
                            mem_wdata = set_link(cur_ent_reg, bit_b, '0);
                        end
                        pool_cmd.push = 1'b1;
                        push_idx      = nx_reg;
                        chain_next    = 1'b1;
                        if (last) begin
                            state_next = S_DONE;
                        end
                    end
                end
            end

            S_CHECK: begin
                if ((op_reg == OP_INSERT) && (sat_reg || short_pool)) begin
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end else begin
                    phase2_next   = 1'b1;
                    cur_root_next = 1'b1;
                    cur_ent_next  = {{COUNT_BITS{1'b0}}, root_reg};
                    lvl_next      = LVL_W'(KEY_BITS - 1);
                    state_next    = S_STEP;
                end
            end

            S_ALLOC: begin
                // The parent gets the new link; the new node is written when it
                // becomes a parent itself, or in the flush at the end.
                if (cur_root_reg) begin
                    root_next = root_new_ent[2*LINK_W-1:0];
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = cur_idx_reg;
                    mem_wdata = set_link(cur_ent_reg, bit_b, new_link);
                end
                cur_root_next = 1'b0;
                cur_idx_next  = pop_idx;
                cur_ent_next  = {COUNT_BITS'(1), {(2*LINK_W){1'b0}}};
                lvl_next      = lvl_reg - LVL_W'(1);
                state_next    = last ? S_FLUSH : S_STEP;
            end

            S_FLUSH: begin
                mem_we     = !cur_root_reg;
                state_next = S_DONE;
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_max_xor_next = res_reg;
                    m_status_next  = status_reg;
                    state_next     = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            root_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            root_reg    <= root_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        res_reg       <= res_next;
        status_reg    <= status_next;
        lvl_reg       <= lvl_next;
        depth_reg     <= depth_next;
        sat_reg       <= sat_next;
        phase2_reg    <= phase2_next;
        chain_reg     <= chain_next;
        cur_root_reg  <= cur_root_next;
        cur_idx_reg   <= cur_idx_next;
        cur_ent_reg   <= cur_ent_next;
        nx_reg        <= nx_next;
        m_max_xor_reg <= m_max_xor_next;
        m_status_reg  <= m_status_next;
    end

    // A new request is taken whenever the walker is idle, even with a result waiting.
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_max_xor = m_max_xor_reg;
    assign m_status  = m_status_reg;

`ifndef SYNTHESIS
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_cnt <= CNT_W'(NODE_COUNT))
        else $error("free node count exceeds the pool size");

    a_alloc_after_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ALLOC) |-> $past(state_reg == S_STEP))
        else $error("node allocation without a pop request");

    a_rdwait_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RDWAIT) |-> $past(mem_re))
        else $error("node data used without a read");

    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re && (mem_waddr == mem_raddr)))
        else $error("node read and write hit the same entry");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_EMPTY)) |-> (m_max_xor == '0))
        else $error("empty-set result carries a nonzero value");
`endif

endmodule
